[sv/wsht_pkg.sv]
// ----------------------------------------------------------------------------
// wsht_pkg
// Shared types and constants of the window slot table and hit test core.
// ----------------------------------------------------------------------------
package wsht_pkg;

   localparam int SLOT_COUNT_DEF = 16;

   localparam int COORD_W  = 12;
   localparam int TITLE_W  = 7;
   localparam int KIND_W   = 2;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam int WND_WIDTH  = 600;
   localparam int WND_HEIGHT = 300;

   localparam logic [COORD_W-1:0] WIN_HALF_W = COORD_W'(WND_WIDTH / 2);
   localparam logic [COORD_W-1:0] WIN_HALF_H = COORD_W'(WND_HEIGHT / 2);

   localparam logic [COORD_W-1:0] FB_WIDTH_RST  = 12'd1024;
   localparam logic [COORD_W-1:0] FB_HEIGHT_RST = 12'd768;
   localparam logic [TITLE_W-1:0] TITLE_RST     = 7'd20;

   localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HIT     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_HIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TITLE     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CREATE,
      ST_HIT
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    window_id;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
   } rsp_type;

endpackage

[sv/wsht_hit_cmp.sv]
// ----------------------------------------------------------------------------
// wsht_hit_cmp
// Rectangle containment test of one slot against the latched point, with the
// top edge raised by the title bar and right and bottom edges inclusive.
// ----------------------------------------------------------------------------
module wsht_hit_cmp (
   input  logic [wsht_pkg::COORD_W-1:0] left,
   input  logic [wsht_pkg::COORD_W-1:0] top,
   input  logic [wsht_pkg::COORD_W-1:0] point_x,
   input  logic [wsht_pkg::COORD_W-1:0] point_y,
   input  logic [wsht_pkg::TITLE_W-1:0] title_bar_height,
   output logic                         hit
);
   import wsht_pkg::*;

   logic [COORD_W:0] left_ext;
   logic [COORD_W:0] top_ext;
   logic [COORD_W:0] px_ext;
   logic [COORD_W:0] py_ext;
   logic [COORD_W:0] right_edge;
   logic [COORD_W:0] bottom_edge;
   logic [COORD_W:0] py_raised;

   always_comb begin
      left_ext    = {1'b0, left};
      top_ext     = {1'b0, top};
      px_ext      = {1'b0, point_x};
      py_ext      = {1'b0, point_y};
      right_edge  = left_ext + (COORD_W + 1)'(WND_WIDTH);
      bottom_edge = top_ext + (COORD_W + 1)'(WND_HEIGHT);
      py_raised   = py_ext + (COORD_W + 1)'(title_bar_height);
      hit = (px_ext >= left_ext) && (px_ext <= right_edge) &&
            (py_raised >= top_ext) && (py_ext <= bottom_edge);
   end

endmodule

[sv/window_slot_table_hit_test_core.sv]
// ----------------------------------------------------------------------------
// window_slot_table_hit_test_core
// Window slot table with create, destroy and point hit test, scanned one slot
// per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on rsp_data for one cycle with rsp_strobe and must be captured then.
// Destroy and unused kinds answer on the cycle after the command. Create scans
// the in-use bits one slot per cycle from slot 0 and takes the lowest free one,
// or answers full after the last slot. Hit test reads the coordinate memory
// one slot per cycle with a registered read and answers with the lowest in-use
// slot that holds the point, or with no hit after the last slot. The result
// strobe follows in the next cycle, during which busy is already low.
// The configuration port is always ready; it is to be written only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module window_slot_table_hit_test_core #(
   parameter int SLOT_COUNT = wsht_pkg::SLOT_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  wsht_pkg::req_type              req_data,
   output logic                           rsp_strobe,
   output wsht_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wsht_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wsht_pkg::COORD_W-1:0]   csr_data
);
   import wsht_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
   localparam logic [ID_W-1:0]  ID_LIMIT = ID_W'(SLOT_COUNT);

   logic [COORD_W-1:0] fb_width_ff;
   logic [COORD_W-1:0] fb_height_ff;
   logic [TITLE_W-1:0] title_ff;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [COORD_W-1:0]    px_ff, px_in;
   logic [COORD_W-1:0]    py_ff, py_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_use_ff, rd_use_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;

   logic [COORD_W-1:0] left_mem [SLOT_COUNT];
   logic [COORD_W-1:0] top_mem  [SLOT_COUNT];
   logic [COORD_W-1:0] rd_left_ff;
   logic [COORD_W-1:0] rd_top_ff;

   logic               mem_we;
   logic [IDX_W-1:0]   scan_idx;
   logic [COORD_W-1:0] new_left;
   logic [COORD_W-1:0] new_top;
   logic               accept;
   logic               slot_hit;

   assign csr_ready  = 1'b1;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign accept     = start && !busy;
   assign scan_idx   = cnt_ff[IDX_W-1:0];
   assign new_left   = (fb_width_ff >> 1) - WIN_HALF_W;
   assign new_top    = (fb_height_ff >> 1) - WIN_HALF_H;

   function automatic logic [SLOT_W-1:0] slot_code(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

   wsht_hit_cmp u_hit_cmp (
      .left             (rd_left_ff),
      .top              (rd_top_ff),
      .point_x          (px_ff),
      .point_y          (py_ff),
      .title_bar_height (title_ff),
      .hit              (slot_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= FB_WIDTH_RST;
         fb_height_ff <= FB_HEIGHT_RST;
         title_ff     <= TITLE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FB_WIDTH:  fb_width_ff  <= csr_data;
            CSR_FB_HEIGHT: fb_height_ff <= csr_data;
            CSR_TITLE:     title_ff     <= csr_data[TITLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         left_mem[scan_idx] <= new_left;
         top_mem[scan_idx]  <= new_top;
      end
      rd_left_ff <= left_mem[scan_idx];
      rd_top_ff  <= top_mem[scan_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         in_use_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         in_use_ff     <= in_use_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      rsp_ff    <= rsp_in;
      rd_use_ff <= rd_use_in;
      rd_idx_ff <= rd_idx_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      in_use_in     = in_use_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_vld_in     = 1'b0;
      rd_use_in     = in_use_ff[scan_idx];
      rd_idx_in     = scan_idx;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               px_in  = req_data.point_x;
               py_in  = req_data.point_y;
               priority if (req_data.kind == KIND_CREATE) begin
                  state_in = ST_CREATE;
               end else if (req_data.kind == KIND_HIT) begin
                  state_in = ST_HIT;
               end else begin
                  if (req_data.kind == KIND_DESTROY && req_data.window_id < ID_LIMIT) begin
                     in_use_in[req_data.window_id[IDX_W-1:0]] = 1'b0;
                  end
                  rsp_strobe_in     = 1'b1;
                  rsp_in.status     = STATUS_OK;
                  rsp_in.slot_index = '0;
               end
            end
         end
         ST_CREATE: begin
            priority if (!in_use_ff[scan_idx]) begin
               mem_we              = 1'b1;
               in_use_in[scan_idx] = 1'b1;
               rsp_strobe_in       = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.slot_index   = slot_code(scan_idx);
               state_in            = ST_IDLE;
            end else if (scan_idx == LAST_IDX) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = STATUS_FULL;
               rsp_in.slot_index = '0;
               state_in          = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_HIT: begin
            if (cnt_ff != CNT_END) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            priority if (rd_vld_ff && rd_use_ff && slot_hit) begin
               rd_vld_in         = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = STATUS_OK;
               rsp_in.slot_index = slot_code(rd_idx_ff);
               state_in          = ST_IDLE;
            end else if (rd_vld_ff && rd_idx_ff == LAST_IDX) begin
               rd_vld_in         = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = STATUS_NO_HIT;
               rsp_in.slot_index = '0;
               state_in          = ST_IDLE;
            end else begin
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
